FILE: sv/dct_pkg.sv
// Shared constants, types and register codes for the dark channel transmission block.
// No dependencies; imported by every module of the block but dct_ram.
package dct_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 7;

  // fixed field widths
  localparam int CFG_DIM_W = 11;
  localparam int CFG_RAD_W = 3;
  localparam int CFG_Q_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 8;
  localparam int NORM_W    = 24;
  localparam int TRANS_W   = 25;

  // derived geometry widths
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = COL_W + 1;
  localparam int ROW_W     = $clog2(MAX_HEIGHT) + 1;
  localparam int POS_W     = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int SLOT_BITS = $clog2(2 * MAX_RADIUS + 2);
  localparam int ROW_SLOTS = 1 << SLOT_BITS;
  localparam int ADDR_W    = SLOT_BITS + COL_W;
  localparam int RAM_DEPTH = ROW_SLOTS * MAX_WIDTH;

  // product split for the omega multiply
  localparam int HALF_W    = NORM_W / 2;

  localparam logic [CFG_Q_W-1:0] Q16_ONE = CFG_Q_W'(65536);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RAD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HAZE_KEEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BLUE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_GREEN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RED      = 3'd6;

  // divider result
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
    logic [WID_W-1:0] rem;
  } div_res_t;

  // transmission unit result
  typedef struct packed {
    logic               done;
    logic [TRANS_W-1:0] trans;
  } trans_res_t;

endpackage

FILE: sv/dark_channel_transmission.sv
// Top level of the dark channel transmission estimator: control, line stores, units.
// Depends on dct_pkg, dct_ram, dct_div, dct_trans.
//
// Input words carry func (0 pixel, 1 drain) and blue, green, red in raster order.
// Each pixel is reduced to its channel minimum and to the minimum of the channels
// scaled by the airlight reciprocals; both are written into line stores of 16 row
// slots. A result word (dark_value, transmission, frame_end) leaves as soon as
// every pixel of its clamped square window has arrived; drain words flush the rest.
// Words are handled one at a time; a word that yields a result makes one line store
// read per window pixel. After a frame_width write the first word passes through the
// divider twice to recompute row and column of both positions. Results sit in an
// output register; while the receiver stalls, the block keeps taking words until a
// new result must be loaded. Reset restores the register defaults and returns both
// positions to zero; the line stores are not cleared and need no clearing pass.
// Configuration writes are taken in any cycle and are meant for idle periods.
module dark_channel_transmission (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [dct_pkg::PIX_W-1:0]     in_blue,
  input  logic [dct_pkg::PIX_W-1:0]     in_green,
  input  logic [dct_pkg::PIX_W-1:0]     in_red,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dct_pkg::PIX_W-1:0]     out_dark_value,
  output logic signed [dct_pkg::TRANS_W-1:0] out_transmission,
  output logic                          out_frame_end,
  input  logic                          cfg_we,
  input  logic [dct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dct_pkg::CFG_Q_W-1:0]   cfg_data
);
  import dct_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIX     = 4'd1;
  localparam logic [3:0] S_DIV_IN  = 4'd2;
  localparam logic [3:0] S_DIV_OUT = 4'd3;
  localparam logic [3:0] S_WRITE   = 4'd4;
  localparam logic [3:0] S_CHECK   = 4'd5;
  localparam logic [3:0] S_NEED    = 4'd6;
  localparam logic [3:0] S_SCAN    = 4'd7;
  localparam logic [3:0] S_LAST    = 4'd8;
  localparam logic [3:0] S_TSTART  = 4'd9;
  localparam logic [3:0] S_TWAIT   = 4'd10;
  localparam logic [3:0] S_EMIT    = 4'd11;

  localparam int PROD_W = PIX_W + CFG_Q_W;

  // configuration registers
  logic [CFG_DIM_W-1:0] cfg_w_r, cfg_h_r;
  logic [CFG_RAD_W-1:0] cfg_rad_r;
  logic [CFG_Q_W-1:0]   cfg_om_r, cfg_ib_r, cfg_ig_r, cfg_ir_r;
  logic                 dirty_r, dirty_nxt;

  logic [WID_W-1:0]   w_c;
  logic [ROW_W-1:0]   h_c;
  logic [CFG_RAD_W-1:0] rad_c;
  logic [CFG_Q_W-1:0] om_c, ib_c, ig_c, ir_c;
  logic [POS_W-1:0]   total_r;

  // control state
  logic [3:0]       state_r, state_nxt;
  logic [POS_W-1:0] in_pos_r, in_pos_nxt, out_pos_r, out_pos_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;

  // item and scan registers
  logic             func_r;
  logic [PIX_W-1:0] blue_r, green_r, red_r;
  logic [PROD_W-1:0] pb_r, pg_r, pr_r;
  logic [ROW_W-1:0] r0_r, r0_nxt, r1_r, r1_nxt, x_r, x_nxt;
  logic [COL_W-1:0] c0_r, c0_nxt, c1_r, c1_nxt, y_r, y_nxt;
  logic [POS_W-1:0] need_r, need_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [PIX_W-1:0] dark_r, dark_nxt;
  logic [NORM_W-1:0] norm_r, norm_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_dark_r;
  logic [TRANS_W-1:0] out_trans_r;
  logic               out_fe_r;
  logic               load_out, frame_end_c;

  // memories and units
  logic               ram_we;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [PIX_W-1:0]   raw_wdata, raw_rdata;
  logic [NORM_W-1:0]  norm_wdata, norm_rdata;
  logic               div_start;
  logic [POS_W-1:0]   div_dvd;
  div_res_t           div_res;
  logic               trans_start;
  trans_res_t         trans_res;

  // clamped configuration
  always_comb begin
    if (cfg_w_r == '0) w_c = WID_W'(1);
    else if (32'(cfg_w_r) > MAX_WIDTH) w_c = WID_W'(MAX_WIDTH);
    else w_c = WID_W'(cfg_w_r);
    if (cfg_h_r == '0) h_c = ROW_W'(1);
    else if (32'(cfg_h_r) > MAX_HEIGHT) h_c = ROW_W'(MAX_HEIGHT);
    else h_c = ROW_W'(cfg_h_r);
    rad_c = (32'(cfg_rad_r) > MAX_RADIUS) ? CFG_RAD_W'(MAX_RADIUS) : cfg_rad_r;
    om_c  = (cfg_om_r > Q16_ONE) ? Q16_ONE : cfg_om_r;
    ib_c  = (cfg_ib_r > Q16_ONE) ? Q16_ONE : cfg_ib_r;
    ig_c  = (cfg_ig_r > Q16_ONE) ? Q16_ONE : cfg_ig_r;
    ir_c  = (cfg_ir_r > Q16_ONE) ? Q16_ONE : cfg_ir_r;
  end

  // per pixel minima from the registered products
  always_comb begin
    logic [PROD_W-1:0] m;
    raw_wdata = (blue_r < green_r) ? blue_r : green_r;
    raw_wdata = (red_r < raw_wdata) ? red_r : raw_wdata;
    m = (pb_r < pg_r) ? pb_r : pg_r;
    m = (pr_r < m) ? pr_r : m;
    norm_wdata = NORM_W'(m);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign ram_we    = (state_r == S_WRITE) && !func_r && (in_pos_r < total_r);
  assign waddr     = {in_row_r[SLOT_BITS-1:0], in_col_r};
  assign raddr     = {x_r[SLOT_BITS-1:0], y_r};
  assign div_start = ((state_r == S_FIX) && (out_pos_r < total_r) && dirty_r)
                   || ((state_r == S_DIV_IN) && div_res.done);
  assign div_dvd   = (state_r == S_FIX) ? in_pos_r : out_pos_r;
  assign trans_start = (state_r == S_TSTART);
  assign load_out  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign frame_end_c = ((out_pos_r + 1'b1) >= total_r) && (in_pos_r >= total_r);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    dirty_nxt   = dirty_r;
    in_pos_nxt  = in_pos_r;
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_pos_nxt = out_pos_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    r0_nxt      = r0_r;
    r1_nxt      = r1_r;
    c0_nxt      = c0_r;
    c1_nxt      = c1_r;
    need_nxt    = need_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    rd_pend_nxt = 1'b0;
    dark_nxt    = dark_r;
    norm_nxt    = norm_r;
    if (rd_pend_r) begin
      if (raw_rdata < dark_r) dark_nxt = raw_rdata;
      if (norm_rdata < norm_r) norm_nxt = norm_rdata;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_FIX;
      end
      S_FIX: begin
        if (out_pos_r >= total_r) begin
          in_pos_nxt  = '0;
          out_pos_nxt = '0;
          in_row_nxt  = '0;
          in_col_nxt  = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
          dirty_nxt   = 1'b0;
          state_nxt   = S_WRITE;
        end else if (dirty_r) begin
          state_nxt = S_DIV_IN;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_DIV_IN: begin
        if (div_res.done) begin
          in_row_nxt = div_res.quot[ROW_W-1:0];
          in_col_nxt = div_res.rem[COL_W-1:0];
          state_nxt  = S_DIV_OUT;
        end
      end
      S_DIV_OUT: begin
        if (div_res.done) begin
          out_row_nxt = div_res.quot[ROW_W-1:0];
          out_col_nxt = div_res.rem[COL_W-1:0];
          dirty_nxt   = 1'b0;
          state_nxt   = S_WRITE;
        end
      end
      S_WRITE: begin
        if (ram_we) begin
          in_pos_nxt = in_pos_r + 1'b1;
          if ({1'b0, in_col_r} + 1'b1 == w_c) begin
            in_col_nxt = '0;
            in_row_nxt = in_row_r + 1'b1;
          end else begin
            in_col_nxt = in_col_r + 1'b1;
          end
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // clamped window bounds and the last raster position it needs
        r0_nxt = (out_row_r > ROW_W'(rad_c)) ? out_row_r - ROW_W'(rad_c) : '0;
        r1_nxt = (out_row_r + ROW_W'(rad_c) < h_c - 1'b1)
               ? out_row_r + ROW_W'(rad_c) : h_c - 1'b1;
        c0_nxt = (out_col_r > COL_W'(rad_c)) ? out_col_r - COL_W'(rad_c) : '0;
        c1_nxt = ({1'b0, out_col_r} + WID_W'(rad_c) < w_c - 1'b1)
               ? out_col_r + COL_W'(rad_c) : COL_W'(w_c - 1'b1);
        need_nxt = POS_W'(r1_nxt) * POS_W'(w_c) + POS_W'(c1_nxt);
        state_nxt = (out_pos_r < total_r) ? S_NEED : S_IDLE;
      end
      S_NEED: begin
        if (need_r >= in_pos_r) begin
          state_nxt = S_IDLE;
        end else begin
          x_nxt     = r0_r;
          y_nxt     = c0_r;
          dark_nxt  = '1;
          norm_nxt  = '1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_pend_nxt = 1'b1;
        if (y_r == c1_r) begin
          y_nxt = c0_r;
          x_nxt = x_r + 1'b1;
          if (x_r == r1_r) state_nxt = S_LAST;
        end else begin
          y_nxt = y_r + 1'b1;
        end
      end
      S_LAST: begin
        state_nxt = S_TSTART;
      end
      S_TSTART: begin
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        if (trans_res.done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (load_out) begin
          if (frame_end_c) begin
            in_pos_nxt  = '0;
            out_pos_nxt = '0;
            in_row_nxt  = '0;
            in_col_nxt  = '0;
            out_row_nxt = '0;
            out_col_nxt = '0;
          end else begin
            out_pos_nxt = out_pos_r + 1'b1;
            if ({1'b0, out_col_r} + 1'b1 == w_c) begin
              out_col_nxt = '0;
              out_row_nxt = out_row_r + 1'b1;
            end else begin
              out_col_nxt = out_col_r + 1'b1;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we && cfg_index == REG_FRAME_WIDTH) dirty_nxt = 1'b1;
  end

  // output register handoff
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dirty_r     <= 1'b0;
      in_pos_r    <= '0;
      out_pos_r   <= '0;
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      in_pos_r    <= in_pos_nxt;
      out_pos_r   <= out_pos_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= CFG_DIM_W'(640);
      cfg_h_r   <= CFG_DIM_W'(480);
      cfg_rad_r <= CFG_RAD_W'(7);
      cfg_om_r  <= CFG_Q_W'(62259);
      cfg_ib_r  <= CFG_Q_W'(257);
      cfg_ig_r  <= CFG_Q_W'(257);
      cfg_ir_r  <= CFG_Q_W'(257);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_w_r   <= cfg_data[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_h_r   <= cfg_data[CFG_DIM_W-1:0];
        REG_WINDOW_RAD:   cfg_rad_r <= cfg_data[CFG_RAD_W-1:0];
        REG_HAZE_KEEP:    cfg_om_r  <= cfg_data;
        REG_INV_BLUE:     cfg_ib_r  <= cfg_data;
        REG_INV_GREEN:    cfg_ig_r  <= cfg_data;
        REG_INV_RED:      cfg_ir_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    total_r <= POS_W'(w_c) * POS_W'(h_c);
    if (state_r == S_IDLE && in_valid) begin
      func_r  <= in_func;
      blue_r  <= in_blue;
      green_r <= in_green;
      red_r   <= in_red;
    end
    pb_r   <= blue_r * ib_c;
    pg_r   <= green_r * ig_c;
    pr_r   <= red_r * ir_c;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    c0_r   <= c0_nxt;
    c1_r   <= c1_nxt;
    need_r <= need_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    dark_r <= dark_nxt;
    norm_r <= norm_nxt;
    if (load_out) begin
      out_dark_r  <= dark_r;
      out_trans_r <= trans_res.trans;
      out_fe_r    <= frame_end_c;
    end
  end

  // line stores
  dct_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_raw_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (raw_wdata),
    .raddr (raddr),
    .rdata (raw_rdata)
  );

  dct_ram #(.WIDTH(NORM_W), .DEPTH(RAM_DEPTH)) u_norm_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (norm_wdata),
    .raddr (raddr),
    .rdata (norm_rdata)
  );

  dct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (w_c),
    .res      (div_res)
  );

  dct_trans u_trans (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trans_start),
    .omega (om_c),
    .norm  (norm_r),
    .res   (trans_res)
  );

  assign out_valid        = out_valid_r;
  assign out_dark_value   = out_dark_r;
  assign out_transmission = out_trans_r;
  assign out_frame_end    = out_fe_r;

  // results never run ahead of the pixels taken
  a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_pos_r <= in_pos_r)
    else $error("result position passed input position");

  // a frame end word restarts both positions
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && frame_end_c) |=> (in_pos_r == '0 && out_pos_r == '0))
    else $error("positions not cleared after frame end");

  // a new result only comes from the emit step
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result word raised outside emit");

  // no line store write while a window scan reads
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_LAST) |-> !ram_we)
    else $error("line store written during scan");

endmodule

FILE: sv/dct_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module dct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/dct_div.sv
// Restoring divider, one quotient bit per cycle: raster position by row width.
// Depends on dct_pkg.
module dct_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [dct_pkg::POS_W-1:0] dividend,
  input  logic [dct_pkg::WID_W-1:0] divisor,
  output dct_pkg::div_res_t       res
);
  import dct_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] dvd_r, dvd_nxt;
  logic [WID_W-1:0] dsr_r, dsr_nxt;
  logic [WID_W-1:0] rem_r, rem_nxt;
  logic [WID_W:0]   trial;

  // one shift and subtract step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[POS_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(POS_W);
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = WID_W'(trial - {1'b0, dsr_r});
        dvd_nxt = {dvd_r[POS_W-2:0], 1'b1};
      end else begin
        rem_nxt = WID_W'(trial);
        dvd_nxt = {dvd_r[POS_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.quot = dvd_r;
  assign res.rem  = rem_r;

endmodule

FILE: sv/dct_trans.sv
// Transmission unit: 1 - round(omega * norm / 65536) with the product split in halves.
// Depends on dct_pkg.
module dct_trans (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dct_pkg::CFG_Q_W-1:0]  omega,
  input  logic [dct_pkg::NORM_W-1:0] norm,
  output dct_pkg::trans_res_t        res
);
  import dct_pkg::*;

  localparam int PP_W  = CFG_Q_W + HALF_W;
  localparam int SUM_W = PP_W + HALF_W;

  logic [1:0]         ph_r, ph_nxt;
  logic               done_r, done_nxt;
  logic [CFG_Q_W-1:0] om_r;
  logic [NORM_W-1:0]  nm_r;
  logic [PP_W-1:0]    plo_r, phi_r;
  logic [TRANS_W-1:0] trans_r, trans_nxt;
  logic [SUM_W-1:0]   sum;

  // rounding sum of the partial products
  always_comb begin
    sum       = {phi_r, {HALF_W{1'b0}}} + SUM_W'(plo_r) + SUM_W'(32768);
    trans_nxt = TRANS_W'(Q16_ONE) - sum[16 +: TRANS_W];
    done_nxt  = (ph_r == 2'd3);
    ph_nxt    = ph_r;
    if (start) begin
      ph_nxt = 2'd1;
    end else if (ph_r != 2'd0) begin
      ph_nxt = ph_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    if (start) begin
      om_r <= omega;
      nm_r <= norm;
    end
    if (ph_r == 2'd1) begin
      plo_r <= om_r * nm_r[HALF_W-1:0];
    end
    if (ph_r == 2'd2) begin
      phi_r <= om_r * nm_r[NORM_W-1:HALF_W];
    end
    if (ph_r == 2'd3) begin
      trans_r <= trans_nxt;
    end
  end

  assign res.done  = done_r;
  assign res.trans = trans_r;

endmodule
